[src/pnk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pnk_pkg;

    localparam int ROW_W    = 16;
    localparam int SAMPLE_W = 16;
    localparam int SCALE_W  = 15;
    localparam int MUL_W    = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 1;

    localparam logic [63:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94D049BB133111EB;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 15'd17695;

    localparam logic [CFG_IDX_W-1:0] REG_SEED  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_M_LL,
        ST_M_HL,
        ST_M_LH,
        ST_M_SUM,
        ST_WRITE,
        ST_SCALE,
        ST_SCALE_W,
        ST_DIV_W,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

[src/pink_noise_generator_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// An accepted advance transaction redraws n rows, n = 1..ROWS (all ROWS on counter wrap);
// each row runs ADD, two rounds of M_LL, M_HL, M_LH, M_SUM, then WRITE.
// Throughput: one transaction at a time; s_ready returns with m_valid, and stays low
// while an older result waits in OUT.
// Each redrawn row uses the single registered 32x32 multiplier.
// A tick with s_advance low is accepted in IDLE and yields no result.
// Reset: rows, row sum, counter and generator state cleared; scale_reg = 17695.
module pink_noise_generator_core #(
    parameter int ROWS = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_advance,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [pnk_pkg::SAMPLE_W-1:0]         m_sample,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [pnk_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [pnk_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int CLOG  = $clog2(ROWS);
    localparam int IDX_W = (CLOG > 0) ? CLOG : 1;
    localparam int SUM_W = 16 + CLOG;
    localparam int K     = SUM_W + CLOG;
    localparam int RECIP = ((2 ** K) + ROWS - 1) / ROWS;
    localparam logic [SUM_W-1:0]            OFFSET  = SUM_W'(ROWS * 32768);
    localparam logic [pnk_pkg::MUL_W-1:0]   RECIP_W = pnk_pkg::MUL_W'(RECIP);

    pnk_pkg::state_t state_reg, state_next;

    logic [ROWS-1:0]                 cnt_reg, cnt_next;
    logic [ROWS-1:0]                 diff_reg, diff_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [63:0]                     gen_reg, gen_next;
    logic [pnk_pkg::SCALE_W-1:0]     scale_reg, scale_next;
    logic                            mix_sel_reg, mix_sel_next;
    logic                            m_valid_reg, m_valid_next;
    logic [63:0]                     z_reg, z_next;
    logic [63:0]                     acc_reg, acc_next;
    logic [pnk_pkg::SAMPLE_W-1:0]    res_reg, res_next;
    logic [pnk_pkg::SAMPLE_W-1:0]    m_sample_reg, m_sample_next;

    logic [pnk_pkg::MUL_W-1:0]       mul_a, mul_b;
    logic [2*pnk_pkg::MUL_W-1:0]     mul_p;

    logic                            row_wr_en;
    logic signed [pnk_pkg::ROW_W-1:0] row_value;
    logic signed [SUM_W-1:0]         sum;

    logic [63:0]                     g_add;
    logic [63:0]                     mix_const;
    logic [31:0]                     prod_hi;
    logic [63:0]                     prod;
    logic [SUM_W-1:0]                sum_biased;
    logic [ROWS-1:0]                 diff_shift;
    logic [15:0]                     quot;

    pnk_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (mul_p)
    );

    pnk_rows #(
        .ROWS  (ROWS),
        .IDX_W (IDX_W),
        .SUM_W (SUM_W)
    ) u_rows (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (row_wr_en),
        .wr_idx   (idx_reg),
        .wr_value (row_value),
        .sum_reg  (sum)
    );

    assign s_ready  = (state_reg == pnk_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

    assign g_add      = gen_reg + pnk_pkg::GOLDEN_STEP;
    assign mix_const  = mix_sel_reg ? pnk_pkg::MIX_MUL_B : pnk_pkg::MIX_MUL_A;
    assign prod_hi    = acc_reg[63:32] + mul_p[31:0];
    assign prod       = {prod_hi, acc_reg[31:0]};
    assign sum_biased = $unsigned(sum) + OFFSET;
    assign diff_shift = diff_reg >> 1;
    assign quot       = mul_p[K +: 16];
    assign row_value  = {~z_reg[63], z_reg[62:48]};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pnk_pkg::ST_IDLE: begin
                if (s_valid && s_advance) begin
                    state_next = pnk_pkg::ST_ADD;
                end
            end
            pnk_pkg::ST_ADD:   state_next = pnk_pkg::ST_M_LL;
            pnk_pkg::ST_M_LL:  state_next = pnk_pkg::ST_M_HL;
            pnk_pkg::ST_M_HL:  state_next = pnk_pkg::ST_M_LH;
            pnk_pkg::ST_M_LH:  state_next = pnk_pkg::ST_M_SUM;
            pnk_pkg::ST_M_SUM: begin
                state_next = mix_sel_reg ? pnk_pkg::ST_WRITE : pnk_pkg::ST_M_LL;
            end
            pnk_pkg::ST_WRITE: begin
                state_next = diff_shift[0] ? pnk_pkg::ST_ADD : pnk_pkg::ST_SCALE;
            end
            pnk_pkg::ST_SCALE:   state_next = pnk_pkg::ST_SCALE_W;
            pnk_pkg::ST_SCALE_W: state_next = pnk_pkg::ST_DIV_W;
            pnk_pkg::ST_DIV_W:   state_next = pnk_pkg::ST_OUT;
            pnk_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = pnk_pkg::ST_IDLE;
                end
            end
            default: state_next = pnk_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cnt_next      = cnt_reg;
        diff_next     = diff_reg;
        idx_next      = idx_reg;
        gen_next      = gen_reg;
        scale_next    = scale_reg;
        mix_sel_next  = mix_sel_reg;
        z_next        = z_reg;
        acc_next      = acc_reg;
        res_next      = res_reg;
        m_sample_next = m_sample_reg;
        m_valid_next  = m_valid_reg;
        mul_a         = '0;
        mul_b         = '0;
        row_wr_en     = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            pnk_pkg::ST_IDLE: begin
                if (s_valid && s_advance) begin
                    cnt_next  = cnt_reg + ROWS'(1);
                    diff_next = cnt_reg ^ cnt_next;
                    idx_next  = '0;
                end
                if (cfg_wr_en) begin
                    case (cfg_index)
                        pnk_pkg::REG_SEED:  gen_next   = cfg_data;
                        pnk_pkg::REG_SCALE: scale_next = cfg_data[pnk_pkg::SCALE_W-1:0];
                        default: ;
                    endcase
                end
            end
            pnk_pkg::ST_ADD: begin
                gen_next     = g_add;
                z_next       = g_add ^ (g_add >> 30);
                mix_sel_next = 1'b0;
            end
            pnk_pkg::ST_M_LL: begin
                mul_a = z_reg[31:0];
                mul_b = mix_const[31:0];
            end
            pnk_pkg::ST_M_HL: begin
                mul_a    = z_reg[63:32];
                mul_b    = mix_const[31:0];
                acc_next = mul_p;
            end
            pnk_pkg::ST_M_LH: begin
                mul_a    = z_reg[31:0];
                mul_b    = mix_const[63:32];
                acc_next = {acc_reg[63:32] + mul_p[31:0], acc_reg[31:0]};
            end
            pnk_pkg::ST_M_SUM: begin
                if (mix_sel_reg) begin
                    z_next       = prod ^ (prod >> 31);
                    mix_sel_next = 1'b0;
                end else begin
                    z_next       = prod ^ (prod >> 27);
                    mix_sel_next = 1'b1;
                end
            end
            pnk_pkg::ST_WRITE: begin
                row_wr_en = 1'b1;
                diff_next = diff_shift;
                idx_next  = idx_reg + IDX_W'(1);
            end
            pnk_pkg::ST_SCALE: begin
                mul_a = pnk_pkg::MUL_W'(sum_biased);
                mul_b = pnk_pkg::MUL_W'(scale_reg);
            end
            pnk_pkg::ST_SCALE_W: begin
                mul_a = pnk_pkg::MUL_W'(mul_p[15 +: SUM_W]);
                mul_b = RECIP_W;
            end
            pnk_pkg::ST_DIV_W: begin
                res_next = quot - {1'b0, scale_reg};
            end
            pnk_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = res_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pnk_pkg::ST_IDLE;
            cnt_reg     <= '0;
            diff_reg    <= '0;
            idx_reg     <= '0;
            gen_reg     <= '0;
            scale_reg   <= pnk_pkg::SCALE_RESET;
            mix_sel_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            diff_reg    <= diff_next;
            idx_reg     <= idx_next;
            gen_reg     <= gen_next;
            scale_reg   <= scale_next;
            mix_sel_reg <= mix_sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        z_reg        <= z_next;
        acc_reg      <= acc_next;
        res_reg      <= res_next;
        m_sample_reg <= m_sample_next;
    end

endmodule

`default_nettype wire

[src/pnk_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

module pnk_mul (
    input  wire logic                          aclk,
    input  wire logic [pnk_pkg::MUL_W-1:0]     op_a,
    input  wire logic [pnk_pkg::MUL_W-1:0]     op_b,
    output logic      [2*pnk_pkg::MUL_W-1:0]   prod_reg
);

    logic [2*pnk_pkg::MUL_W-1:0] prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

[src/pnk_rows.sv]
`timescale 1ns / 1ps
`default_nettype none

module pnk_rows #(
    parameter int ROWS  = 16,
    parameter int IDX_W = 4,
    parameter int SUM_W = 20
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              wr_en,
    input  wire logic        [IDX_W-1:0]           wr_idx,
    input  wire logic signed [pnk_pkg::ROW_W-1:0]  wr_value,
    output logic signed      [SUM_W-1:0]           sum_reg
);

    logic signed [pnk_pkg::ROW_W-1:0] row_reg [ROWS];
    logic signed [pnk_pkg::ROW_W-1:0] old_value;
    logic signed [SUM_W-1:0]          sum_next;

    assign old_value = row_reg[wr_idx];
    assign sum_next  = sum_reg + SUM_W'(wr_value) - SUM_W'(old_value);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            for (int r = 0; r < ROWS; r++) begin
                row_reg[r] <= '0;
            end
        end else if (wr_en) begin
            sum_reg         <= sum_next;
            row_reg[wr_idx] <= wr_value;
        end
    end

endmodule

`default_nettype wire
